// File: hdl/mcc_pkg.sv
// Shared types and constants for the millisecond clock to calendar block.
// No dependencies.
package mcc_pkg;

  localparam int unsigned SEC_W = 32;

  // Controller states, one-hot.
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_DIV   = 10'b0000000010,
    ST_CARRY = 10'b0000000100,
    ST_SPLIT = 10'b0000001000,
    ST_ERA   = 10'b0000010000,
    ST_SPAN  = 10'b0000100000,
    ST_YEAR  = 10'b0001000000,
    ST_DOY   = 10'b0010000000,
    ST_DATE  = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

  localparam logic KIND_POLL = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;       // reload counter from cfg_data, clear base
    logic load;       // take the input item
    logic div_step;   // one digit of the ms carry division
    logic div_done;   // apply quotient and remainder
    logic split;      // seconds into days
    logic era;        // day of era, time of day
    logic span;       // year-of-era numerator
    logic year;       // year of era, hour and minute count
    logic doy;        // day of year
    logic date;       // month, day and output load
  } cmd_t;

  typedef struct packed {
    logic is_poll_delta; // polled item that moves the counter
    logic div_last;      // last division step
  } sts_t;

endpackage

// File: hdl/mcc_ctrl.sv
// Controller: sequences one item through carry division and calendar steps.
// Depends on mcc_pkg.
module mcc_ctrl
  import mcc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  input  logic in_fire,
  input  logic out_busy,
  input  sts_t sts,
  output logic idle,
  output logic out_set,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign idle = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    out_set = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cfg_valid) begin
          cmd.init = 1'b1;
        end else if (in_fire) begin
          cmd.load = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_CARRY;
        end
      end
      ST_CARRY: begin
        cmd.div_done = sts.is_poll_delta;
        state_next = ST_SPLIT;
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        state_next = ST_ERA;
      end
      ST_ERA: begin
        cmd.era = 1'b1;
        state_next = ST_SPAN;
      end
      ST_SPAN: begin
        cmd.span = 1'b1;
        state_next = ST_YEAR;
      end
      ST_YEAR: begin
        cmd.year = 1'b1;
        state_next = ST_DOY;
      end
      ST_DOY: begin
        cmd.doy = 1'b1;
        state_next = ST_DATE;
      end
      ST_DATE: begin
        cmd.date = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy) begin
          out_set = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/mcc_dp.sv
// Datapath: clock state, digit-wise reciprocal millisecond carry division,
// calendar math. Depends on mcc_pkg.
module mcc_dp
  import mcc_pkg::*;
#(
  parameter int unsigned MS_PER_SECOND = 1000
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [31:0] cfg_data,
  input  logic        kind,
  input  logic [31:0] now_ms,
  input  logic [31:0] set_seconds,
  output sts_t        sts,
  output logic [31:0] unix_seconds,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  localparam int unsigned DW = 11;             // dividend digit width
  localparam int unsigned SW = 3 * DW;         // remainder + delta width
  localparam logic [10:0] DIVISOR = 11'(MS_PER_SECOND);
  // ceil(2^31 / divisor): exact for every digit step below divisor * 2^11
  localparam logic [30:0] RECIP =
    31'(((64'd1 << 31) + 64'(MS_PER_SECOND) - 64'd1) / 64'(MS_PER_SECOND));

  logic [31:0] seconds_count;
  logic [31:0] last_stamp;
  logic [9:0]  ms_remainder;
  logic        base_valid;
  logic        poll_delta;
  logic [31:0] delta;

  // Division state: three 11-bit digits, most significant first.
  logic [SW-1:0] dividend;
  logic [SW-1:0] quo;
  logic [9:0]    rem;
  logic [1:0]    cnt;
  logic [20:0]   div_y;
  logic [41:0]   div_p;
  logic [10:0]   div_q;
  logic [20:0]   div_r;

  assign delta = now_ms - last_stamp;
  assign div_y = {rem, dividend[SW-1 -: DW]};
  assign div_p = 42'(div_y) * 42'(RECIP);
  assign div_q = 11'(div_p >> 31);
  assign div_r = div_y - 21'(div_q) * 21'(DIVISOR);

  assign sts.is_poll_delta = poll_delta;
  assign sts.div_last      = (cnt == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_count <= '0;
      last_stamp    <= '0;
      ms_remainder  <= '0;
      base_valid    <= 1'b0;
      poll_delta    <= 1'b0;
    end else if (cmd.init) begin
      seconds_count <= cfg_data;
      last_stamp    <= '0;
      ms_remainder  <= '0;
      base_valid    <= 1'b0;
    end else if (cmd.load) begin
      poll_delta <= 1'b0;
      if (kind == KIND_SET) begin
        seconds_count <= set_seconds;
      end else if (!base_valid) begin
        last_stamp <= now_ms;
        base_valid <= 1'b1;
      end else begin
        last_stamp <= now_ms;
        poll_delta <= 1'b1;
      end
    end else if (cmd.div_done) begin
      seconds_count <= seconds_count + 32'(quo);
      ms_remainder  <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dividend <= SW'(delta) + SW'(ms_remainder);
      quo <= '0;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      dividend <= {dividend[SW-DW-1:0], {DW{1'b0}}};
      quo      <= {quo[SW-DW-1:0], div_q};
      rem      <= 10'(div_r);
      cnt      <= cnt + 2'd1;
    end
  end

  // Calendar conversion by reciprocal multiplies.
  logic [15:0] days;
  logic [16:0] sod;
  logic        era5;
  logic [17:0] doe;
  logic [17:0] yoe_num;
  logic [8:0]  yoe;
  logic [8:0]  doy;
  logic [10:0] min_total;
  logic [4:0]  hour_q;

  logic [63:0] p_day;
  logic [17:0] doe_next;
  logic [35:0] p_c1460;
  logic [2:0]  c36524;
  logic [17:0] yoe_num_next;
  logic [35:0] p_yoe;
  logic [33:0] p_hour;
  logic [34:0] p_min;
  logic [17:0] p_c100;
  logic [8:0]  doy_next;
  logic [10:0] mnum;
  logic [23:0] p_mp;
  logic [3:0]  mp;
  logic [8:0]  mstart;
  logic [3:0]  mo_w;
  logic [11:0] yr_base;

  always_comb begin
    p_day = 64'(seconds_count) * 64'd3257812231;   // /86400, shift 48
    // Days up to 2000-02-29 fall in the era from 1600, later ones in the era from 2000.
    doe_next = (days >= 16'd11017) ? 18'(days) - 18'd11017 : 18'(days) + 18'd135080;
    // yoe = (doe - doe/1460 + doe/36524 - doe/146096) / 365
    p_c1460 = 36'(doe) * 36'd45965;                // /1460, shift 26
    c36524  = 3'(doe >= 18'd36524) + 3'(doe >= 18'd73048)
              + 3'(doe >= 18'd109572) + 3'(doe >= 18'd146096);
    yoe_num_next = doe - 18'(p_c1460 >> 26) + 18'(c36524) - 18'(doe == 18'd146096);
    p_yoe  = 36'(yoe_num) * 36'd183860;           // /365, shift 26
    p_hour = 34'(sod) * 34'd37283;                // /3600, shift 27
    p_min  = 35'(sod) * 35'd139811;               // /60, shift 23
    p_c100 = 18'(yoe) * 18'd41;                   // /100, shift 12
    doy_next = 9'(doe - (18'(yoe) * 18'd365 + 18'(yoe >> 2) - 18'(p_c100 >> 12)));
    mnum = 11'(doy) * 11'd5 + 11'd2;
    p_mp = 24'(mnum) * 24'd6854;                  // /153, shift 20
    mp   = 4'(p_mp >> 20);
    // First day of each month counted from March 1
    unique case (mp)
      4'd0:    mstart = 9'd0;
      4'd1:    mstart = 9'd31;
      4'd2:    mstart = 9'd61;
      4'd3:    mstart = 9'd92;
      4'd4:    mstart = 9'd122;
      4'd5:    mstart = 9'd153;
      4'd6:    mstart = 9'd184;
      4'd7:    mstart = 9'd214;
      4'd8:    mstart = 9'd245;
      4'd9:    mstart = 9'd275;
      4'd10:   mstart = 9'd306;
      4'd11:   mstart = 9'd337;
      default: mstart = 9'd0;
    endcase
    mo_w    = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
    yr_base = (era5 ? 12'd2000 : 12'd1600) + 12'(yoe);
  end

  always_ff @(posedge clk) begin
    if (cmd.split) begin
      days <= 16'(p_day >> 48);
    end
    if (cmd.era) begin
      sod  <= 17'(seconds_count - 32'(days) * 32'd86400);
      era5 <= (days >= 16'd11017);
      doe  <= doe_next;
    end
    if (cmd.span) begin
      yoe_num <= yoe_num_next;
    end
    if (cmd.year) begin
      yoe       <= 9'(p_yoe >> 26);
      hour_q    <= 5'(p_hour >> 27);
      min_total <= 11'(p_min >> 23);
    end
    if (cmd.doy) begin
      doy <= doy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.date) begin
      unix_seconds <= seconds_count;
      month  <= mo_w;
      day    <= 5'(doy - mstart + 9'd1);
      year   <= yr_base + ((mo_w <= 4'd2) ? 12'd1 : 12'd0);
      hour   <= hour_q;
      minute <= 6'(min_total - 11'(hour_q) * 11'd60);
      second <= 6'(sod - 17'(min_total) * 17'd60);
    end
  end

endmodule

// File: hdl/millisecond_clock_to_calendar.sv
// Top level of the millisecond clock to calendar block.
// Depends on mcc_pkg, mcc_ctrl and mcc_dp.
//
// Every item (poll or set) runs the same path: three digit steps of the millisecond
// carry division, one to apply the carry, six calendar steps, one output load. The
// next item can be accepted from the cycle its result appears, not before, so items
// never overlap. A result not yet taken holds the following item in its output step.
// Configuration writes are taken only while no item is in flight.
module millisecond_clock_to_calendar
  import mcc_pkg::*;
#(
  parameter int unsigned MS_PER_SECOND = 1000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // now_ms, set_seconds
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // unix_seconds, year, month, day, hour, minute, second
);

  cmd_t cmd;
  sts_t sts;
  logic idle, out_set, in_fire;
  logic [31:0] unix_seconds;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day, hour;
  logic [5:0]  minute, second;

  assign cfg_ready = idle;
  assign s_tready  = idle && !cfg_valid;
  assign in_fire   = s_tvalid && s_tready;

  mcc_ctrl u_ctrl (
    .clk, .rst, .cfg_valid, .in_fire,
    .out_busy(m_tvalid && !m_tready), .sts, .idle, .out_set, .cmd
  );

  mcc_dp #(.MS_PER_SECOND(MS_PER_SECOND)) u_dp (
    .clk, .rst, .cmd, .cfg_data, .kind(s_tuser),
    .now_ms(s_tdata[31:0]), .set_seconds(s_tdata[63:32]), .sts,
    .unix_seconds, .year, .month, .day, .hour, .minute, .second
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_set) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_set) begin
      m_tdata <= {2'b0, second, minute, hour, day, month, year, unix_seconds};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid || m_tready || idle)
    else $error("input taken while busy");
  a_out_after_set: assert property (@(posedge clk) disable iff (rst)
    out_set |=> m_tvalid)
    else $error("result lost");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.init |-> idle)
    else $error("config while busy");
`endif

endmodule

// File: tb/tb_millisecond_clock_to_calendar.sv
// Testbench for millisecond_clock_to_calendar: drives poll and set items,
// predicts seconds and civil date per item, checks every result in order.
// Depends on mcc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_millisecond_clock_to_calendar;
  import mcc_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [31:0] now_ms;
    logic [31:0] set_seconds;
  } clk_item_t;

  // most significant field first, matching the result packing
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [31:0] unix_seconds;
  } calendar_t;

  localparam int unsigned MS_PER_SEC = 1000;
  localparam longint unsigned LIMIT_CYCLES = 2000000;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;

  millisecond_clock_to_calendar dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // predictor state
  logic [31:0] start_secs;
  logic [31:0] secs_count;
  logic [31:0] last_ms;
  logic [9:0]  ms_rem;
  logic        base_latched;

  clk_item_t pending_items[$];
  calendar_t expected_dates[$];
  int        errors;
  int        send_idle_pct;
  int        recv_idle_pct;
  longint unsigned cycles;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic calendar_t to_calendar(logic [31:0] s);
    calendar_t c;
    longint unsigned days, sod, shifted, era, doe, yoe, doy, mp, yr, mo;
    days = s / 86400;
    sod = s % 86400;
    shifted = days + 719468;
    era = shifted / 146097;
    doe = shifted - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    yr = yoe + era * 400;
    mo = (mp < 10) ? mp + 3 : mp - 9;
    if (mo <= 2) yr++;
    c.unix_seconds = s;
    c.year = yr[11:0];
    c.month = mo[3:0];
    c.day = 5'(doy - (153 * mp + 2) / 5 + 1);
    c.hour = 5'(sod / 3600);
    c.minute = 6'((sod % 3600) / 60);
    c.second = 6'(sod % 60);
    return c;
  endfunction

  function automatic void restart_clock();
    secs_count = start_secs;
    last_ms = '0;
    ms_rem = '0;
    base_latched = 1'b0;
  endfunction

  function automatic void advance_clock(clk_item_t it);
    logic [31:0] delta;
    longint unsigned total;
    if (it.kind == KIND_SET) begin
      secs_count = it.set_seconds;
    end else if (!base_latched) begin
      last_ms = it.now_ms;
      base_latched = 1'b1;
    end else begin
      delta = it.now_ms - last_ms;
      total = longint'(ms_rem) + longint'(delta);
      last_ms = it.now_ms;
      secs_count = secs_count + 32'(total / MS_PER_SEC);
      ms_rem = 10'(total % MS_PER_SEC);
    end
    expected_dates.push_back(to_calendar(secs_count));
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        advance_clock(pending_items.pop_front());
      end
      if ((!s_tvalid || s_tready) && pending_items.size() > 0
          && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tuser <= pending_items[0].kind;
        s_tdata <= {pending_items[0].set_seconds, pending_items[0].now_ms};
      end else if (s_tvalid && s_tready) begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    calendar_t got, want;
    cycles <= cycles + 1;
    if (!rst) begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_tvalid && m_tready) begin
        got = m_tdata[69:0];
        if (expected_dates.size() == 0) begin
          report_mismatch("unexpected result, seconds", got.unix_seconds, 0);
        end else begin
          want = expected_dates.pop_front();
          if (got.unix_seconds !== want.unix_seconds)
            report_mismatch("unix_seconds", got.unix_seconds, want.unix_seconds);
          if (got.year !== want.year) report_mismatch("year", got.year, want.year);
          if (got.month !== want.month) report_mismatch("month", got.month, want.month);
          if (got.day !== want.day) report_mismatch("day", got.day, want.day);
          if (got.hour !== want.hour) report_mismatch("hour", got.hour, want.hour);
          if (got.minute !== want.minute)
            report_mismatch("minute", got.minute, want.minute);
          if (got.second !== want.second)
            report_mismatch("second", got.second, want.second);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("millisecond_clock_to_calendar: mismatch");
      $finish;
    end
  end

  function automatic void queue_item(logic kind, logic [31:0] ms, logic [31:0] secs);
    clk_item_t it;
    it.kind = kind;
    it.now_ms = ms;
    it.set_seconds = secs;
    pending_items.push_back(it);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(3))
      0: return 32'hFFFF_FFFF - $urandom_range(2000);
      1: return $urandom_range(2000);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || s_tvalid || expected_dates.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_start(logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    start_secs = value;
    restart_clock();
  endtask

  // random phase: mostly polls with small steps, some big jumps and sets
  task automatic random_items(int n);
    logic [31:0] stamp;
    stamp = rand_word();
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: queue_item(KIND_SET, $urandom, rand_word());
        1: begin
          stamp = stamp + $urandom;
          queue_item(KIND_POLL, stamp, $urandom);
        end
        default: begin
          stamp = stamp + $urandom_range(3000);
          queue_item(KIND_POLL, stamp, $urandom);
        end
      endcase
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = KIND_POLL;
    m_tready = 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 53;
    start_secs = '0;
    restart_clock();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: base latch, wrap of the stamp, huge sums, counter overflow
    queue_item(KIND_POLL, 32'hFFFF_FF00, 32'hFFFF_FFFF);
    queue_item(KIND_POLL, 32'h0000_0100, 32'h0);
    queue_item(KIND_POLL, 32'h0000_0101, 32'h0);
    queue_item(KIND_POLL, 32'h0000_0100, 32'h0);
    queue_item(KIND_POLL, 32'hFFFF_FFFF, 32'h0);
    queue_item(KIND_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(KIND_SET, 32'h0, 32'h0);
    queue_item(KIND_SET, 32'h0, 32'd951782400);  // leap day 2000
    queue_item(KIND_SET, 32'h0, 32'd4107542400); // 2100-03-01, no leap day
    queue_item(KIND_SET, 32'h0, 32'hFFFF_FFF0);
    queue_item(KIND_POLL, 32'h0000_0100 + 32'd999, 32'h0);
    queue_item(KIND_POLL, 32'h0000_0100 + 32'd60000, 32'h0);
    queue_item(KIND_POLL, 32'h0000_0100 + 32'd60001, 32'h0);
    wait_drained();

    write_start(32'hFFFF_FFFF);
    queue_item(KIND_POLL, 32'd5, 32'h0);
    queue_item(KIND_POLL, 32'd2005, 32'h0);
    wait_drained();

    write_start(32'd1234567890);
    random_items(450);
    wait_drained();

    send_idle_pct = 53;
    recv_idle_pct = 6;
    write_start($urandom);
    random_items(450);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_start(32'h0);
    random_items(430);
    wait_drained();

    if (errors == 0) begin
      $display("millisecond_clock_to_calendar: match");
    end else begin
      $display("millisecond_clock_to_calendar: mismatch");
    end
    $finish;
  end

endmodule
